[rtl/fmsd_pkg.sv]
// ----------------------------------------------------------------------------
// fmsd_pkg
// Shared constants and types for the first-match word delete block.
// ----------------------------------------------------------------------------
package fmsd_pkg;

	// longest word the window can hold
	localparam int WORD_MAX = 8;
	localparam int BYTE_W   = 8;
	localparam int KEY_W    = 64;
	localparam int LEN_W    = 4;
	// fill count must hold 0..WORD_MAX
	localparam int FILL_W   = $clog2(WORD_MAX + 1);

	// configuration register indexes
	localparam logic REG_WORD_BYTES  = 1'b0;
	localparam logic REG_WORD_LENGTH = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	// per-cell control from the window sequencer
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctl_t;

	// one result item
	typedef struct packed {
		byte_t kept_byte;
		logic  byte_present;
		logic  run_end;
		logic  outcome;
	} result_t;

endpackage

[rtl/first_match_substring_delete.sv]
// ----------------------------------------------------------------------------
// first_match_substring_delete
// Removes the first occurrence of a configured word from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Sentence bytes enter on sent_valid/sent_stall, one transfer per byte, with
//   sentence_end on the final byte. Results leave on kept_valid/kept_stall.
//   The word (up to 8 bytes, first byte in bits 7..0) and its length are
//   written on the cfg channel (cfg_ready is always high) between sentences.
//   A row of eight byte cells holds the window; a step inserts any accepted
//   byte, compares all cells with the word in parallel and, once the window
//   is full, pops the oldest or drops all on the first match. Throughput:
//   one byte per cycle in steady state. A byte that causes several results
//   (up to 8) takes one step per result, and surplus bytes left by a lowered
//   word length are popped ahead of a match one per step; the input stalls
//   meanwhile. Each result is registered in the output buffer before it leaves.
//   A two-entry output buffer lets one more step complete while the receiver
//   stalls; after that the input stalls too. Nothing is lost or repeated.
//   Reset clears the window, the match flag and both registers (word empty).
// ----------------------------------------------------------------------------
module first_match_substring_delete import fmsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// sentence channel
	input  logic             sent_valid,
	output logic             sent_stall,
	input  logic [7:0]       sentence_byte,
	input  logic             sentence_end,
	// result channel
	output logic             kept_valid,
	input  logic             kept_stall,
	output logic [7:0]       kept_byte,
	output logic             byte_present,
	output logic             run_end,
	output logic             outcome,
	// configuration channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [KEY_W-1:0] cfg_data
);

	logic [KEY_W-1:0]  word_bytes_q;
	logic [LEN_W-1:0]  word_length_q;
	logic [FILL_W-1:0] fill_q;
	logic              match_seen_q;
	logic              drain_q;
	logic              last_q;
	logic              cmp_pend_q;

	logic [FILL_W-1:0] len_eff;
	logic [FILL_W-1:0] ins_pos;
	logic [FILL_W-1:0] fill_w;
	logic              last_w;
	logic              cmp_w;
	logic              space;
	logic              accept;
	logic              step_en;

	byte_t             work [WORD_MAX];
	logic [WORD_MAX-1:0] eq_here;
	logic [WORD_MAX-1:0] eq_prev;
	cell_ctl_t         ctl [WORD_MAX];
	logic              eq0;
	logic              eq1;

	logic              emit;
	result_t           res;
	logic              pop;
	logic              finish;
	logic              set_match;
	logic              done;
	logic              oc;
	logic [FILL_W-1:0] fill_n;
	logic              cmp_n;
	result_t           head_res;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_bytes_q  <= '0;
			word_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WORD_BYTES:  word_bytes_q  <= cfg_data;
				REG_WORD_LENGTH: word_length_q <= cfg_data[LEN_W-1:0];
				default:         word_bytes_q  <= word_bytes_q;
			endcase
		end
	end

	// effective length and insert slot
	assign len_eff = (word_length_q > LEN_W'(WORD_MAX)) ? FILL_W'(WORD_MAX)
		: FILL_W'(word_length_q);
	assign ins_pos = (fill_q > FILL_W'(WORD_MAX - 1)) ? FILL_W'(WORD_MAX - 1) : fill_q;

	// handshake and step enable
	assign sent_stall = drain_q || !space;
	assign accept     = sent_valid && !sent_stall;
	assign step_en    = drain_q ? space : accept;

	// working view of the window for this step
	assign fill_w = drain_q ? fill_q : ins_pos + FILL_W'(1);
	assign last_w = drain_q ? last_q : sentence_end;
	assign cmp_w  = drain_q ? cmp_pend_q : 1'b1;

	// row of window cells
	for (genvar g = 0; g < WORD_MAX; g++) begin : g_cell
		byte_t right_byte;
		byte_t key_prev;

		if (g == WORD_MAX - 1) begin : g_tail
			assign right_byte = '0;
		end else begin : g_mid
			assign right_byte = work[g+1];
		end

		if (g == 0) begin : g_head
			assign key_prev = word_bytes_q[BYTE_W-1:0];
		end else begin : g_rest
			assign key_prev = word_bytes_q[(g-1)*BYTE_W +: BYTE_W];
		end

		assign ctl[g].insert = accept && (ins_pos == FILL_W'(g));
		assign ctl[g].pop    = step_en && pop;

		fmsd_cell u_cell (
			.clk        (clk),
			.load_byte  (sentence_byte),
			.ctl        (ctl[g]),
			.right_byte (right_byte),
			.key_here   (word_bytes_q[g*BYTE_W +: BYTE_W]),
			.key_prev   (key_prev),
			.work_byte  (work[g]),
			.eq_here    (eq_here[g]),
			.eq_prev    (eq_prev[g])
		);
	end

	// window equals word, aligned at the oldest cell and one cell further in
	always_comb begin
		eq0 = 1'b1;
		eq1 = 1'b1;
		for (int i = 0; i < WORD_MAX; i++) begin
			if (FILL_W'(i) < len_eff) begin
				eq0 = eq0 && eq_here[i];
				if (i + 1 < WORD_MAX) begin
					eq1 = eq1 && eq_prev[i+1];
				end else begin
					eq1 = 1'b0;
				end
			end
		end
	end

	assign oc = (len_eff != '0) && !match_seen_q;

	// one window step: surplus pop, compare, or flush
	always_comb begin
		emit             = 1'b0;
		res.kept_byte    = work[0];
		res.byte_present = 1'b1;
		res.run_end      = 1'b0;
		res.outcome      = 1'b0;
		pop              = 1'b0;
		finish           = 1'b0;
		set_match        = 1'b0;
		done             = 1'b1;
		fill_n           = fill_w;
		cmp_n            = cmp_w;
		priority if (fill_w > len_eff) begin
			// window longer than the word: pass the oldest byte
			emit   = 1'b1;
			pop    = 1'b1;
			fill_n = fill_w - FILL_W'(1);
			if (last_w) begin
				res.run_end = ((len_eff == '0) && (fill_w == FILL_W'(1)))
					|| ((len_eff != '0) && (fill_w == len_eff + FILL_W'(1))
					&& !match_seen_q && eq1);
				done   = res.run_end;
				finish = res.run_end;
			end else begin
				done = (len_eff == '0) && (fill_w == FILL_W'(1));
			end
		end else if ((len_eff != '0) && (fill_w == len_eff) && cmp_w) begin
			// full window: drop it on the first match, else pass the oldest
			if (!match_seen_q && eq0) begin
				set_match = 1'b1;
				fill_n    = '0;
				if (last_w) begin
					emit             = 1'b1;
					res.kept_byte    = '0;
					res.byte_present = 1'b0;
					res.run_end      = 1'b1;
					finish           = 1'b1;
				end
			end else begin
				emit   = 1'b1;
				pop    = 1'b1;
				fill_n = fill_w - FILL_W'(1);
				cmp_n  = 1'b0;
				if (last_w) begin
					res.run_end = (fill_w == FILL_W'(1));
					res.outcome = res.run_end && oc;
					done        = res.run_end;
					finish      = res.run_end;
				end
			end
		end else if (last_w) begin
			// flush what is left, or send the status alone
			emit   = 1'b1;
			finish = 1'b1;
			if (fill_w != '0) begin
				pop         = 1'b1;
				fill_n      = fill_w - FILL_W'(1);
				res.run_end = (fill_w == FILL_W'(1));
				res.outcome = res.run_end && oc;
				done        = res.run_end;
				finish      = res.run_end;
			end else begin
				res.kept_byte    = '0;
				res.byte_present = 1'b0;
				res.run_end      = 1'b1;
				res.outcome      = oc;
			end
		end else begin
			done = 1'b1;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			match_seen_q <= 1'b0;
			drain_q      <= 1'b0;
			last_q       <= 1'b0;
			cmp_pend_q   <= 1'b0;
		end else if (step_en) begin
			fill_q       <= finish ? '0 : fill_n;
			match_seen_q <= finish ? 1'b0 : (match_seen_q || set_match);
			drain_q      <= !done;
			last_q       <= last_w;
			cmp_pend_q   <= cmp_n;
		end
	end

	// result buffer
	fmsd_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step_en && emit),
		.push_res   (res),
		.space      (space),
		.kept_valid (kept_valid),
		.kept_stall (kept_stall),
		.head_res   (head_res)
	);

	assign kept_byte    = head_res.kept_byte;
	assign byte_present = head_res.byte_present;
	assign run_end      = head_res.run_end;
	assign outcome      = head_res.outcome;

	// between items the window never holds a full word-max of bytes
	a_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!drain_q |-> (fill_q <= FILL_W'(WORD_MAX - 1)))
		else $error("window overfull between items");

	// the end mark leaves the block with a cleared window
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && emit && res.run_end) |=>
		((fill_q == '0) && !match_seen_q && !drain_q))
		else $error("window not cleared after end of sentence");

	// a status-only result is always the last of its sentence
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && emit && !res.byte_present) |-> res.run_end)
		else $error("status-only result without end mark");

endmodule

[rtl/fmsd_cell.sv]
// ----------------------------------------------------------------------------
// fmsd_cell
// One byte of the sliding window: takes a new byte, shifts toward the oldest
// end, and compares its byte against two word positions.
// ----------------------------------------------------------------------------
module fmsd_cell import fmsd_pkg::*; (
	input  logic      clk,
	input  byte_t     load_byte,
	input  cell_ctl_t ctl,
	input  byte_t     right_byte,
	input  byte_t     key_here,
	input  byte_t     key_prev,
	output byte_t     work_byte,
	output logic      eq_here,
	output logic      eq_prev
);

	byte_t data_q;

	// view of this cell once the new byte is in place
	assign work_byte = ctl.insert ? load_byte : data_q;

	// compare at its own word position and at the one before it
	assign eq_here = (work_byte == key_here);
	assign eq_prev = (work_byte == key_prev);

	// shift from the younger neighbor on a pop
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			data_q <= right_byte;
		end else begin
			data_q <= work_byte;
		end
	end

endmodule

[rtl/fmsd_out_buf.sv]
// ----------------------------------------------------------------------------
// fmsd_out_buf
// Two-entry result buffer: output register plus skid register, so the window
// keeps working for one more result while the receiver stalls.
// ----------------------------------------------------------------------------
module fmsd_out_buf import fmsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_res,
	output logic    space,
	output logic    kept_valid,
	input  logic    kept_stall,
	output result_t head_res
);

	logic    head_v_q;
	logic    skid_v_q;
	result_t head_q;
	result_t skid_q;
	logic    pop;

	assign pop        = head_v_q && !kept_stall;
	assign space      = !skid_v_q;
	assign kept_valid = head_v_q;
	assign head_res   = head_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (head_v_q) begin
			if (push && !pop) begin
				skid_v_q <= 1'b1;
			end else if (!push && pop) begin
				head_v_q <= 1'b0;
			end
		end else if (push) begin
			head_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (push) begin
			if (!head_v_q || pop) begin
				head_q <= push_res;
			end else begin
				skid_q <= push_res;
			end
		end
	end

	// skid entry only exists behind a head entry
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> head_v_q)
		else $error("skid entry without head entry");

	// no result is pushed into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed while buffer full");

	// a stalled head result holds still
	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(head_v_q && kept_stall) |=> (head_v_q && $stable(head_q)))
		else $error("head result changed while stalled");

endmodule
